FILE: design/sgrd_pkg.sv
// ----------------------------------------------------------------------------
// sgrd_pkg
// Shared types, character codes and helpers of the SGR delta encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sgrd_pkg;

	localparam int S_DATA_W      = 80;
	localparam int M_DATA_W      = 8;
	localparam int QUEUE_DEPTH   = 4;

	// colour kinds
	localparam logic [1:0] KIND_DEFAULT = 2'd0;
	localparam logic [1:0] KIND_INDEXED = 2'd1;
	localparam logic [1:0] KIND_RGB     = 2'd2;

	// characters of a sequence
	localparam logic [7:0] CH_ESC    = 8'h1B;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_M      = 8'h6D;
	localparam logic [7:0] CH_ZERO   = 8'h30;

	// sgr numbers
	localparam logic [7:0] FG_BASE    = 8'd30;
	localparam logic [7:0] BG_BASE    = 8'd40;
	localparam logic [7:0] EXT_OFS    = 8'd8;
	localparam logic [7:0] DEF_OFS    = 8'd9;
	localparam logic [7:0] BRIGHT_OFS = 8'd52;
	localparam logic [7:0] SEL_INDEX  = 8'd5;
	localparam logic [7:0] SEL_RGB    = 8'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  idx;
		logic [23:0] rgb;
	} colour_t;

	// one sequence to be sent
	typedef struct packed {
		logic        rst;
		logic [7:0]  new_attrs;
		logic        fg_chg;
		colour_t     fg;
		logic        bg_chg;
		colour_t     bg;
	} job_t;

	function automatic logic [1:0] norm_kind(input logic [1:0] k);
		return (k == KIND_INDEXED || k == KIND_RGB) ? k : KIND_DEFAULT;
	endfunction

	function automatic logic colour_same(input colour_t a, input colour_t b);
		logic same;
		same = (a.kind == b.kind);
		if (a.kind == KIND_INDEXED) begin
			same = same && (a.idx == b.idx);
		end else if (a.kind == KIND_RGB) begin
			same = same && (a.rgb == b.rgb);
		end
		return same;
	endfunction

	function automatic logic [7:0] attr_code(input logic [2:0] bit_idx);
		logic [7:0] code;
		case (bit_idx)
			3'd0:    code = 8'd1;
			3'd1:    code = 8'd2;
			3'd2:    code = 8'd3;
			3'd3:    code = 8'd4;
			3'd4:    code = 8'd5;
			3'd5:    code = 8'd7;
			3'd6:    code = 8'd8;
			default: code = 8'd9;
		endcase
		return code;
	endfunction

	// count of numbers a colour takes in the sequence
	function automatic logic [2:0] col_len(input colour_t c);
		logic [2:0] len;
		case (c.kind)
			KIND_INDEXED: len = (c.idx < 8'd16) ? 3'd1 : 3'd3;
			KIND_RGB:     len = 3'd5;
			default:      len = 3'd1;
		endcase
		return len;
	endfunction

	// number at position pos of a colour's part
	function automatic logic [7:0] col_num(input logic [7:0] base, input colour_t c,
		input logic [2:0] pos);
		logic [7:0] num;
		case (c.kind)
			KIND_INDEXED: begin
				if (c.idx < 8'd8) begin
					num = base + c.idx;
				end else if (c.idx < 8'd16) begin
					num = base + BRIGHT_OFS + c.idx;
				end else begin
					case (pos)
						3'd0:    num = base + EXT_OFS;
						3'd1:    num = SEL_INDEX;
						default: num = c.idx;
					endcase
				end
			end
			KIND_RGB: begin
				case (pos)
					3'd0:    num = base + EXT_OFS;
					3'd1:    num = SEL_RGB;
					3'd2:    num = c.rgb[23:16];
					3'd3:    num = c.rgb[15:8];
					default: num = c.rgb[7:0];
				endcase
			end
			default: num = base + DEF_OFS;
		endcase
		return num;
	endfunction

endpackage

`default_nettype wire

FILE: design/sgrd_front.sv
// ----------------------------------------------------------------------------
// sgrd_front
// Accepts style items, compares them with the style last sent and queues
// a job for every item that changes the style.
// ----------------------------------------------------------------------------
`default_nettype none

module sgrd_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [sgrd_pkg::S_DATA_W-1:0] s_axis_tdata,
	input  wire logic                          q_full,
	output logic                               q_push,
	output sgrd_pkg::job_t                     q_job
);
	import sgrd_pkg::*;

	logic [7:0] held_attrs_q;
	colour_t    held_fg_q;
	colour_t    held_bg_q;

	logic [7:0] attrs;
	colour_t    fg;
	colour_t    bg;
	logic       accept;
	logic       changed;
	logic       rst;

	always_comb begin
		attrs   = s_axis_tdata[7:0];
		fg.kind = norm_kind(s_axis_tdata[9:8]);
		fg.idx  = s_axis_tdata[17:10];
		fg.rgb  = {s_axis_tdata[25:18], s_axis_tdata[33:26], s_axis_tdata[41:34]};
		bg.kind = norm_kind(s_axis_tdata[43:42]);
		bg.idx  = s_axis_tdata[51:44];
		bg.rgb  = {s_axis_tdata[59:52], s_axis_tdata[67:60], s_axis_tdata[75:68]};

		changed = !((attrs == held_attrs_q) && colour_same(fg, held_fg_q)
			&& colour_same(bg, held_bg_q));
		// dropped attribute or colour back to default needs a full reset
		rst = ((held_attrs_q & ~attrs) != 8'd0)
			|| (held_fg_q.kind != KIND_DEFAULT && fg.kind == KIND_DEFAULT)
			|| (held_bg_q.kind != KIND_DEFAULT && bg.kind == KIND_DEFAULT);

		q_job.rst       = rst;
		q_job.new_attrs = rst ? attrs : (attrs & ~held_attrs_q);
		q_job.fg_chg    = rst ? (fg.kind != KIND_DEFAULT) : !colour_same(fg, held_fg_q);
		q_job.fg        = fg;
		q_job.bg_chg    = rst ? (bg.kind != KIND_DEFAULT) : !colour_same(bg, held_bg_q);
		q_job.bg        = bg;
	end

	assign s_axis_tready = !q_full;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign q_push        = accept && changed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_attrs_q <= '0;
			held_fg_q    <= '0;
			held_bg_q    <= '0;
		end else if (q_push) begin
			held_attrs_q <= attrs;
			held_fg_q    <= fg;
			held_bg_q    <= bg;
		end
	end

endmodule

`default_nettype wire

FILE: design/sgrd_queue.sv
// ----------------------------------------------------------------------------
// sgrd_queue
// Short job queue between the classifying front and the byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module sgrd_queue #(
	parameter int DEPTH = sgrd_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  sgrd_pkg::job_t      push_job,
	output logic                full,
	input  wire logic           pop,
	output logic                pop_valid,
	output sgrd_pkg::job_t      pop_job
);
	import sgrd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign full      = (count_q == FULL_CNT);
	assign pop_valid = (count_q != '0);
	assign pop_job   = mem_q[rd_ptr_q];
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: design/sgrd_back.sv
// ----------------------------------------------------------------------------
// sgrd_back
// Byte sequencer: turns one job into the bytes of an SGR escape sequence,
// one byte per cycle while the receiver is ready, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sgrd_back (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       q_valid,
	input  sgrd_pkg::job_t  q_job,
	output logic            q_pop,
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,
	output logic            m_axis_tlast
);
	import sgrd_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_LB   = 5'b00010,
		S_NUM  = 5'b00100,
		S_SEP  = 5'b01000,
		S_M    = 5'b10000
	} state_t;

	state_t     state_q;
	logic       zero_q;
	logic [7:0] mask_q;
	colour_t    fg_q;
	colour_t    bg_q;
	logic [2:0] fg_pos_q;
	logic [2:0] fg_len_q;
	logic [2:0] bg_pos_q;
	logic [2:0] bg_len_q;
	logic [7:0] cur_q;
	logic [1:0] dig_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	logic        advance;
	logic [2:0]  low_idx;
	logic        has_next;
	logic [7:0]  next_val;
	logic [1:0]  hund;
	logic [6:0]  rem;
	logic [14:0] tens_prod;
	logic [3:0]  tens;
	logic [3:0]  ones;
	logic [3:0]  digit;
	logic [1:0]  next_dig;

	assign advance = !out_valid_q || m_axis_tready;
	assign q_pop   = advance && (state_q == S_IDLE) && q_valid;

	always_comb begin
		low_idx = 3'd0;
		for (int k = 7; k >= 0; k--) begin
			if (mask_q[k]) begin
				low_idx = 3'(k);
			end
		end

		has_next = zero_q || (mask_q != 8'd0) || (fg_pos_q != fg_len_q)
			|| (bg_pos_q != bg_len_q);
		if (zero_q) begin
			next_val = 8'd0;
		end else if (mask_q != 8'd0) begin
			next_val = attr_code(low_idx);
		end else if (fg_pos_q != fg_len_q) begin
			next_val = col_num(FG_BASE, fg_q, fg_pos_q);
		end else begin
			next_val = col_num(BG_BASE, bg_q, bg_pos_q);
		end
		next_dig = (next_val >= 8'd100) ? 2'd2 : ((next_val >= 8'd10) ? 2'd1 : 2'd0);

		// decimal digits, tens by reciprocal multiply (exact below 100)
		hund      = (cur_q >= 8'd200) ? 2'd2 : ((cur_q >= 8'd100) ? 2'd1 : 2'd0);
		rem       = 7'(cur_q - 8'd100 * {6'd0, hund});
		tens_prod = 15'({8'd0, rem} * 15'd205);
		tens      = tens_prod[14:11];
		ones      = 4'(rem - 7'd10 * {3'd0, tens});
		case (dig_q)
			2'd2:    digit = {2'd0, hund};
			2'd1:    digit = tens;
			default: digit = ones;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			zero_q      <= 1'b0;
			mask_q      <= '0;
			fg_q        <= '0;
			bg_q        <= '0;
			fg_pos_q    <= '0;
			fg_len_q    <= '0;
			bg_pos_q    <= '0;
			bg_len_q    <= '0;
			cur_q       <= '0;
			dig_q       <= '0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_last_q  <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
			out_last_q  <= 1'b0;
			case (state_q)
				S_IDLE: begin
					out_byte_q <= CH_ESC;
					if (q_valid) begin
						zero_q   <= q_job.rst;
						mask_q   <= q_job.new_attrs;
						fg_q     <= q_job.fg;
						bg_q     <= q_job.bg;
						fg_pos_q <= '0;
						bg_pos_q <= '0;
						fg_len_q <= q_job.fg_chg ? col_len(q_job.fg) : 3'd0;
						bg_len_q <= q_job.bg_chg ? col_len(q_job.bg) : 3'd0;
						state_q  <= S_LB;
					end else begin
						out_valid_q <= 1'b0;
					end
				end
				S_LB, S_SEP: begin
					out_byte_q <= (state_q == S_LB) ? CH_LBRACK : CH_SEMI;
					if (has_next) begin
						cur_q   <= next_val;
						dig_q   <= next_dig;
						state_q <= S_NUM;
						// consume the number just taken
						if (zero_q) begin
							zero_q <= 1'b0;
						end else if (mask_q != 8'd0) begin
							mask_q <= mask_q & (mask_q - 8'd1);
						end else if (fg_pos_q != fg_len_q) begin
							fg_pos_q <= fg_pos_q + 3'd1;
						end else begin
							bg_pos_q <= bg_pos_q + 3'd1;
						end
					end else begin
						state_q <= S_M;
					end
				end
				S_NUM: begin
					out_byte_q <= CH_ZERO + {4'd0, digit};
					if (dig_q != 2'd0) begin
						dig_q <= dig_q - 2'd1;
					end else begin
						state_q <= has_next ? S_SEP : S_M;
					end
				end
				S_M: begin
					out_byte_q <= CH_M;
					out_last_q <= 1'b1;
					state_q    <= S_IDLE;
				end
				default: begin
					out_valid_q <= 1'b0;
					state_q     <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tlast  = out_last_q;

`ifndef ASSERT_OFF
	// the closing byte is always 'm'
	a_last_is_m: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == CH_M)
		else $error("last byte is not m");

	// bytes of one sequence follow without gaps
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
		else $error("gap inside a sequence");

	// escape is followed by the bracket
	a_esc_bracket: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tdata == CH_ESC
		|=> m_axis_tvalid && m_axis_tdata == CH_LBRACK)
		else $error("escape not followed by bracket");
`endif

endmodule

`default_nettype wire

FILE: design/sgr_delta_encoder.sv
// ----------------------------------------------------------------------------
// sgr_delta_encoder
// Emits the ANSI SGR escape sequence that moves the terminal from the style
// last sent to the wanted style.
// ----------------------------------------------------------------------------
// usage:
//   input stream s_axis_*: one wanted style per item, taken when tvalid and
//   tready are both high. an item equal to the style last sent gives no bytes.
//   output stream m_axis_*: one byte of the sequence per item, tlast on the
//   closing 'm'.
//   a front stage compares each item with the held style and queues a job;
//   a byte sequencer drains the queue at one byte per cycle while the
//   receiver is ready, through an output register, so input and output
//   stall independently. an item taken is first written to the job queue;
//   an idle sequencer then takes the job and registers the ESC byte.
//   a changing item gives 4 to 52 bytes; the ESC of a job already queued
//   follows the closing 'm' with no gap.
//   the input keeps taking items until the job queue (QUEUE_DEPTH) is full.
//   a stalled receiver holds the current byte and, once the queue fills,
//   the input.
//   reset: held style is cleared (no attributes, default colours), queue
//   and sequencer empty; the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module sgr_delta_encoder #(
	parameter int QUEUE_DEPTH = sgrd_pkg::QUEUE_DEPTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	// attrs, fg_kind, fg_index, fg_red, fg_green, fg_blue,
	// bg_kind, bg_index, bg_red, bg_green, bg_blue, zero fill
	input  wire logic [sgrd_pkg::S_DATA_W-1:0] s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// out_byte
	output logic [sgrd_pkg::M_DATA_W-1:0]      m_axis_tdata,
	output logic                               m_axis_tlast
);
	import sgrd_pkg::*;

	logic q_full;
	logic q_push;
	job_t push_job;
	logic q_pop;
	logic q_valid;
	job_t pop_job;

	sgrd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_job        (push_job)
	);

	sgrd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.pop_valid(q_valid),
		.pop_job  (pop_job)
	);

	sgrd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_job        (pop_job),
		.q_pop        (q_pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule

`default_nettype wire
